// ===== design/mrrt_pkg.sv =====
package mrrt_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int ADDR_W      = 48;
  localparam int END_W       = ADDR_W + 1;
  localparam int KEY_W       = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REGIONS - 1);

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [1:0] CMD_LOOKUP     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERLAP   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_length;
    logic [KEY_W-1:0]  local_key_in;
    logic [KEY_W-1:0]  remote_key_in;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] local_key_out;
    logic [KEY_W-1:0] remote_key_out;
  } rsp_t;

  // Table entry: end address is kept instead of length so the scan only compares.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [END_W-1:0]  end_addr;
    logic [KEY_W-1:0]  local_key;
    logic [KEY_W-1:0]  remote_key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/mrrt_ram.sv =====
module mrrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/memory_region_range_table_top.sv =====
// Memory region range table: holds up to MAX_REGIONS regions (base, length, local
// key, remote key) and serves one request at a time. Register adds a region into
// the lowest free entry unless it overlaps a held region (overlap status) or the
// table has no free entry (full status); unregister drops every region holding
// the address; lookup returns the keys of the region holding the address, or
// not-found with zero keys. One compare unit checks one entry per cycle as the
// entries stream out of the entry RAM, so a full scan holds the request side
// stalled while it walks every entry; a lookup hit or an overlap ends the scan
// at that entry, and an unused command goes straight to the response state
// without a scan.
// The response sits in an output register, so the next transaction is taken
// while an earlier response still waits.
module memory_region_range_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mrrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mrrt_pkg::rsp_t rsp
);
  import mrrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t             state;
  logic [1:0]         op_cmd;
  logic [ADDR_W-1:0]  op_addr;
  logic [END_W-1:0]   op_end;
  logic [KEY_W-1:0]   op_lk;
  logic [KEY_W-1:0]   op_rk;
  logic [IDX_W-1:0]   scan_idx;
  logic               issue_on;
  logic               chk_pending;
  logic [IDX_W-1:0]   chk_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [1:0]         res_status;
  logic [KEY_W-1:0]   res_lk;
  logic [KEY_W-1:0]   res_rk;
  logic [MAX_REGIONS-1:0] valid;

  logic [ENTRY_W-1:0] rd_data;
  entry_t             ent;
  entry_t             wr_entry;
  logic [END_W-1:0]   a_ext;
  logic [END_W-1:0]   b_ext;
  logic               entry_live;
  logic               holds_addr;
  logic               overlap;
  logic               chk_last;
  logic               rsp_load;
  logic               wr_en;

  // Shared compare unit: one table entry per cycle.
  always_comb begin
    ent        = entry_t'(rd_data);
    a_ext      = {1'b0, op_addr};
    b_ext      = {1'b0, ent.base};
    entry_live = chk_pending && valid[chk_idx];
    holds_addr = entry_live && (b_ext <= a_ext) && (a_ext < ent.end_addr);
    overlap    = entry_live && ((b_ext <= a_ext && a_ext < ent.end_addr) ||
                                (b_ext < op_end && op_end <= ent.end_addr) ||
                                (a_ext <= b_ext && ent.end_addr <= op_end));
    chk_last   = chk_pending && (chk_idx == LAST_IDX);
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_RESP) && (!rsp_valid || !rsp_stall);
  assign wr_en     = rsp_load && (op_cmd == CMD_REGISTER) && (res_status == ST_OK);
  assign wr_entry  = '{base: op_addr, end_addr: op_end, local_key: op_lk, remote_key: op_rk};

  mrrt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_REGIONS)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(free_idx),
    .wr_data(wr_entry),
    .rd_addr(scan_idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      rsp_valid   <= 1'b0;
      issue_on    <= 1'b0;
      chk_pending <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_cmd      <= req.cmd;
            op_addr     <= req.address;
            op_end      <= {1'b0, req.address} + {1'b0, req.region_length};
            op_lk       <= req.local_key_in;
            op_rk       <= req.remote_key_in;
            scan_idx    <= '0;
            chk_pending <= 1'b0;
            free_found  <= 1'b0;
            res_lk      <= '0;
            res_rk      <= '0;
            res_status  <= (req.cmd == CMD_LOOKUP) ? ST_NOT_FOUND : ST_OK;
            if (req.cmd == CMD_REGISTER || req.cmd == CMD_UNREGISTER ||
                req.cmd == CMD_LOOKUP) begin
              issue_on <= 1'b1;
              state    <= S_SCAN;
            end else begin
              issue_on <= 1'b0;
              state    <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          // Read address runs one entry ahead of the compare.
          chk_pending <= issue_on;
          chk_idx     <= scan_idx;
          if (issue_on) begin
            if (scan_idx == LAST_IDX) begin
              issue_on <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (chk_pending) begin
            case (op_cmd)
              CMD_REGISTER: begin
                if (overlap) begin
                  res_status <= ST_OVERLAP;
                  state      <= S_RESP;
                end else begin
                  if (!valid[chk_idx] && !free_found) begin
                    free_found <= 1'b1;
                    free_idx   <= chk_idx;
                  end
                  if (chk_last) begin
                    res_status <= (free_found || !valid[chk_idx]) ? ST_OK : ST_FULL;
                    state      <= S_RESP;
                  end
                end
              end
              CMD_UNREGISTER: begin
                if (holds_addr) begin
                  valid[chk_idx] <= 1'b0;
                end
                if (chk_last) begin
                  state <= S_RESP;
                end
              end
              CMD_LOOKUP: begin
                if (holds_addr) begin
                  res_status <= ST_OK;
                  res_lk     <= ent.local_key;
                  res_rk     <= ent.remote_key;
                  state      <= S_RESP;
                end else if (chk_last) begin
                  state <= S_RESP;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp       <= '{status: res_status, local_key_out: res_lk,
                           remote_key_out: res_rk};
            state     <= S_IDLE;
            if (wr_en) begin
              valid[free_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/mrrt_checker.sv =====
module mrrt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input mrrt_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input mrrt_pkg::rsp_t rsp
);
  import mrrt_pkg::*;

  // Hold a stalled response.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed or dropped");

  // Go busy after taking a transaction.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request side not stalled after a transaction");

  // Carry keys only on a successful response.
  a_keys_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.local_key_out == '0 &&
                                          rsp.remote_key_out == '0)
    else $error("nonzero keys on a failed response");

  // Never answer in the cycle right after a transaction.
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !$rose(rsp_valid))
    else $error("response appeared one cycle after a transaction");

endmodule

bind memory_region_range_table_top mrrt_checker u_mrrt_checker (.*);
